/* src/hpn_pkg.sv */
`timescale 1ns / 1ps
package hpn_pkg;

	localparam int BIN_BITS = 8;
	localparam int PIX_BITS = 8;
	localparam int HEIGHT_BITS = 8;
	localparam int OUT_COUNT_BITS = 24;

	localparam logic [1:0] OP_ACCUMULATE = 2'd0;
	localparam logic [1:0] OP_READ = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam logic [1:0] CH_LIGHTNESS = 2'd0;
	localparam logic [1:0] CH_RED = 2'd1;
	localparam logic [1:0] CH_GREEN = 2'd2;
	localparam logic [1:0] CH_BLUE = 2'd3;

	localparam logic REG_CHANNEL_SELECT = 1'b0;
	localparam logic REG_BAR_HEIGHT = 1'b1;

	localparam logic [1:0] CHANNEL_SELECT_RESET = CH_LIGHTNESS;
	localparam logic [HEIGHT_BITS-1:0] BAR_HEIGHT_RESET = 8'd128;

	typedef struct packed {
		logic capture;
		logic rd_pixel;
		logic rd_bin;
		logic acc_write;
		logic mul;
		logic div_start;
		logic emit;
		logic clear;
	} cmd_t;

	typedef struct packed {
		logic div_done;
	} status_t;

endpackage

/* src/hpn_ctrl.sv */
`timescale 1ns / 1ps
module hpn_ctrl
	import hpn_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] operation,
	input  status_t    status,
	output cmd_t       cmd,
	output logic       busy
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ACC_RD,
		S_ACC_WR,
		S_BIN_RD,
		S_MUL,
		S_DIV_GO,
		S_DIV_WAIT,
		S_CLEAR
	} state_t;

	state_t state_q;
	logic busy_q;
	logic accept;

	assign accept = start && !busy_q;
	assign busy = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (operation)
							OP_ACCUMULATE: begin
								state_q <= S_ACC_RD;
								busy_q <= 1'b1;
							end
							OP_READ: begin
								state_q <= S_BIN_RD;
								busy_q <= 1'b1;
							end
							OP_CLEAR: begin
								state_q <= S_CLEAR;
								busy_q <= 1'b1;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_ACC_RD: state_q <= S_ACC_WR;
				S_ACC_WR: begin
					state_q <= S_IDLE;
					busy_q <= 1'b0;
				end
				S_BIN_RD: state_q <= S_MUL;
				S_MUL: state_q <= S_DIV_GO;
				S_DIV_GO: state_q <= S_DIV_WAIT;
				S_DIV_WAIT: begin
					if (status.div_done) begin
						state_q <= S_IDLE;
						busy_q <= 1'b0;
					end
				end
				S_CLEAR: begin
					state_q <= S_IDLE;
					busy_q <= 1'b0;
				end
				default: begin
					state_q <= S_IDLE;
					busy_q <= 1'b0;
				end
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		cmd.capture = accept;
		case (state_q)
			S_ACC_RD: cmd.rd_pixel = 1'b1;
			S_ACC_WR: cmd.acc_write = 1'b1;
			S_BIN_RD: cmd.rd_bin = 1'b1;
			S_MUL: cmd.mul = 1'b1;
			S_DIV_GO: cmd.div_start = 1'b1;
			S_DIV_WAIT: cmd.emit = status.div_done;
			S_CLEAR: cmd.clear = 1'b1;
			default: cmd.capture = accept;
		endcase
	end

endmodule

/* src/hpn_div.sv */
`timescale 1ns / 1ps
module hpn_div
	import hpn_pkg::*;
#(
	parameter int DIVIDEND_BITS = 32,
	parameter int DIVISOR_BITS = 24
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [DIVIDEND_BITS-1:0] dividend,
	input  logic [DIVISOR_BITS-1:0]  divisor,
	output logic                     done,
	output logic [DIVIDEND_BITS-1:0] quotient
);

	localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1);

	logic [DIVIDEND_BITS-1:0] quo_q;
	logic [DIVISOR_BITS-1:0]  rem_q;
	logic [DIVISOR_BITS-1:0]  dvs_q;
	logic [CNT_BITS-1:0]      cnt_q;
	logic                     run_q;
	logic                     done_q;

	logic [DIVISOR_BITS:0] shifted;
	logic [DIVISOR_BITS:0] diff;
	logic                  fits;

	// one quotient bit a cycle, restoring form
	assign shifted = {rem_q, quo_q[DIVIDEND_BITS-1]};
	assign diff = shifted - {1'b0, dvs_q};
	assign fits = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_BITS'(DIVIDEND_BITS);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_BITS'(1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			quo_q <= {quo_q[DIVIDEND_BITS-2:0], fits};
			rem_q <= fits ? diff[DIVISOR_BITS-1:0] : shifted[DIVISOR_BITS-1:0];
		end
	end

	assign done = done_q;
	assign quotient = quo_q;

endmodule

/* src/hpn_datapath.sv */
`timescale 1ns / 1ps
module hpn_datapath
	import hpn_pkg::*;
#(
	parameter int COUNT_BITS = 24
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cmd_t                      cmd,
	output status_t                   status,
	input  logic [PIX_BITS-1:0]       red,
	input  logic [PIX_BITS-1:0]       green,
	input  logic [PIX_BITS-1:0]       blue,
	input  logic [BIN_BITS-1:0]       bin_index,
	input  logic                      cfg_valid,
	input  logic                      cfg_index,
	input  logic [HEIGHT_BITS-1:0]    cfg_data,
	output logic                      result_valid,
	output logic [HEIGHT_BITS-1:0]    bin_height,
	output logic [OUT_COUNT_BITS-1:0] raw_count,
	output logic [OUT_COUNT_BITS-1:0] peak_count
);

	localparam int BINS = 1 << BIN_BITS;
	localparam int PROD_BITS = COUNT_BITS + HEIGHT_BITS;
	localparam int EXT_BITS = (COUNT_BITS > OUT_COUNT_BITS) ? COUNT_BITS : OUT_COUNT_BITS;

	logic [1:0]             chan_q;
	logic [HEIGHT_BITS-1:0] bar_q;
	logic [PIX_BITS-1:0]    red_q, green_q, blue_q;
	logic [BIN_BITS-1:0]    bin_q;

	logic [COUNT_BITS-1:0] mem [BINS];
	logic [BINS-1:0]       valid_q;
	logic [COUNT_BITS-1:0] rd_q;
	logic                  rdv_q;
	logic [BIN_BITS-1:0]   addr_q;
	logic [COUNT_BITS-1:0] peak_q;
	logic [PROD_BITS-1:0]  prod_q;

	logic                    result_valid_q;
	logic [HEIGHT_BITS-1:0]  height_q;
	logic [COUNT_BITS-1:0]   raw_q;
	logic [COUNT_BITS-1:0]   peak_out_q;

	logic [PIX_BITS-1:0]   hi, lo, pix;
	logic [PIX_BITS:0]     sum;
	logic [BIN_BITS-1:0]   rd_addr;
	logic [COUNT_BITS-1:0] count, incr;
	logic                  div_done;
	logic [PROD_BITS-1:0]  quo;
	logic [HEIGHT_BITS-1:0] height;
	logic [EXT_BITS-1:0]   raw_ext, peak_ext;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q <= CHANNEL_SELECT_RESET;
			bar_q <= BAR_HEIGHT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_CHANNEL_SELECT: chan_q <= cfg_data[1:0];
				REG_BAR_HEIGHT: bar_q <= cfg_data;
				default: bar_q <= bar_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			red_q <= red;
			green_q <= green;
			blue_q <= blue;
			bin_q <= bin_index;
		end
	end

	// lightness is the mean of the largest and smallest component
	always_comb begin
		hi = red_q;
		if (green_q > hi) hi = green_q;
		if (blue_q > hi) hi = blue_q;
		lo = red_q;
		if (green_q < lo) lo = green_q;
		if (blue_q < lo) lo = blue_q;
		sum = {1'b0, hi} + {1'b0, lo};
		case (chan_q)
			CH_RED: pix = red_q;
			CH_GREEN: pix = green_q;
			CH_BLUE: pix = blue_q;
			default: pix = sum[PIX_BITS:1];
		endcase
	end

	assign rd_addr = cmd.rd_bin ? bin_q : pix;

	always_ff @(posedge clk) begin
		if (cmd.rd_pixel || cmd.rd_bin) begin
			rd_q <= mem[rd_addr];
			addr_q <= rd_addr;
		end
		if (cmd.acc_write) begin
			mem[addr_q] <= incr;
		end
	end

	// a bin never written since the last clear reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rdv_q <= 1'b0;
			peak_q <= '0;
		end else begin
			if (cmd.rd_pixel || cmd.rd_bin) rdv_q <= valid_q[rd_addr];
			if (cmd.clear) begin
				valid_q <= '0;
				peak_q <= '0;
			end else if (cmd.acc_write) begin
				valid_q[addr_q] <= 1'b1;
				if (incr > peak_q) peak_q <= incr;
			end
		end
	end

	assign count = rdv_q ? rd_q : '0;
	assign incr = (&count) ? count : count + 1'b1;

	always_ff @(posedge clk) begin
		if (cmd.mul) prod_q <= PROD_BITS'(count) * PROD_BITS'(bar_q);
	end

	hpn_div #(
		.DIVIDEND_BITS(PROD_BITS),
		.DIVISOR_BITS (COUNT_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend(prod_q),
		.divisor (peak_q),
		.done    (div_done),
		.quotient(quo)
	);

	assign status.div_done = div_done;

	always_comb begin
		if (peak_q == '0) begin
			height = '0;
		end else if (|quo[PROD_BITS-1:HEIGHT_BITS]) begin
			height = '1;
		end else begin
			height = quo[HEIGHT_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			height_q <= height;
			raw_q <= count;
			peak_out_q <= peak_q;
		end
	end

	assign raw_ext = EXT_BITS'(raw_q);
	assign peak_ext = EXT_BITS'(peak_out_q);

	assign result_valid = result_valid_q;
	assign bin_height = height_q;
	assign raw_count = raw_ext[OUT_COUNT_BITS-1:0];
	assign peak_count = peak_ext[OUT_COUNT_BITS-1:0];

endmodule

/* src/pixel_histogram_peak_normalize.sv */
`timescale 1ns / 1ps
// no new item is accepted while busy; accumulate: S_ACC_RD, S_ACC_WR; clear: S_CLEAR
// read: S_BIN_RD, S_MUL, S_DIV_GO, S_DIV_WAIT; busy drops as the strobe is registered;
// the bar height comes from a bit-serial divider, one quotient bit per cycle
// the result strobe lasts one cycle and cannot be stalled
// asynchronous reset empties the histogram and peak at once and loads register defaults
module pixel_histogram_peak_normalize
	import hpn_pkg::*;
#(
	parameter int COUNT_BITS = 24
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [1:0]                operation,
	input  logic [PIX_BITS-1:0]       red,
	input  logic [PIX_BITS-1:0]       green,
	input  logic [PIX_BITS-1:0]       blue,
	input  logic [BIN_BITS-1:0]       bin_index,
	output logic                      result_valid,
	output logic [HEIGHT_BITS-1:0]    bin_height,
	output logic [OUT_COUNT_BITS-1:0] raw_count,
	output logic [OUT_COUNT_BITS-1:0] peak_count,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic                      cfg_index,
	input  logic [HEIGHT_BITS-1:0]    cfg_data
);

	cmd_t    cmd;
	status_t status;

	assign cfg_ready = 1'b1;

	hpn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.operation(operation),
		.status   (status),
		.cmd      (cmd),
		.busy     (busy)
	);

	hpn_datapath #(
		.COUNT_BITS(COUNT_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.bin_index   (bin_index),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.result_valid(result_valid),
		.bin_height  (bin_height),
		.raw_count   (raw_count),
		.peak_count  (peak_count)
	);

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
	import hpn_pkg::*;

	localparam int CNT_BITS = 24;
	localparam logic [CNT_BITS-1:0] CNT_MAX = {CNT_BITS{1'b1}};
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 48;
	localparam int STALL_LIMIT = 2000;
	localparam int PHASE_ITEMS = 72;
	localparam int NUM_PHASES = 8;

	typedef struct {
		logic [HEIGHT_BITS-1:0] height;
		logic [OUT_COUNT_BITS-1:0] count;
		logic [OUT_COUNT_BITS-1:0] peak;
	} bin_reading_t;

	typedef struct {
		logic [1:0] op;
		logic [PIX_BITS-1:0] r;
		logic [PIX_BITS-1:0] g;
		logic [PIX_BITS-1:0] b;
		logic [BIN_BITS-1:0] idx;
		bit typed;
		bin_reading_t want;
	} directed_row_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [1:0] operation;
	logic [PIX_BITS-1:0] red;
	logic [PIX_BITS-1:0] green;
	logic [PIX_BITS-1:0] blue;
	logic [BIN_BITS-1:0] bin_index;
	logic result_valid;
	logic [HEIGHT_BITS-1:0] bin_height;
	logic [OUT_COUNT_BITS-1:0] raw_count;
	logic [OUT_COUNT_BITS-1:0] peak_count;
	logic cfg_valid;
	logic cfg_ready;
	logic cfg_index;
	logic [HEIGHT_BITS-1:0] cfg_data;

	// shadow of the histogram
	logic [CNT_BITS-1:0] hist_bins [256];
	logic [CNT_BITS-1:0] hist_peak;
	logic [1:0] sel_channel;
	logic [HEIGHT_BITS-1:0] scale_height;

	bin_reading_t pending_reads [$];
	int mismatches = 0;
	int items_sent = 0;
	int reads_checked = 0;
	int cfg_writes = 0;
	int stall_cycles = 0;

	directed_row_t dir_tab [20] = '{
		'{OP_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, '{8'd0, 24'd0, 24'd0}},
		'{OP_READ, 8'd0, 8'd0, 8'd0, 8'd255, 1'b1, '{8'd0, 24'd0, 24'd0}},
		'{OP_ACCUMULATE, 8'd255, 8'd255, 8'd255, 8'd0, 1'b0, '{8'd0, 24'd0, 24'd0}},
		'{OP_ACCUMULATE, 8'd0, 8'd0, 8'd0, 8'd255, 1'b0, '{8'd0, 24'd0, 24'd0}},
		'{OP_ACCUMULATE, 8'd255, 8'd0, 8'd128, 8'd0, 1'b0, '{8'd0, 24'd0, 24'd0}},
		'{OP_ACCUMULATE, 8'd0, 8'd255, 8'd0, 8'd0, 1'b0, '{8'd0, 24'd0, 24'd0}},
		'{OP_ACCUMULATE, 8'd10, 8'd200, 8'd90, 8'd0, 1'b0, '{8'd0, 24'd0, 24'd0}},
		'{OP_READ, 8'd0, 8'd0, 8'd0, 8'd127, 1'b1, '{8'd128, 24'd2, 24'd2}},
		'{OP_READ, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1, '{8'd64, 24'd1, 24'd2}},
		'{OP_READ, 8'd0, 8'd0, 8'd0, 8'd105, 1'b0, '{8'd0, 24'd0, 24'd0}},
		'{OP_READ, 8'd0, 8'd0, 8'd0, 8'd1, 1'b1, '{8'd0, 24'd0, 24'd2}},
		// unused code must leave the histogram alone
		'{OP_UNUSED, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0, '{8'd0, 24'd0, 24'd0}},
		'{OP_UNUSED, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, '{8'd0, 24'd0, 24'd0}},
		'{OP_READ, 8'd0, 8'd0, 8'd0, 8'd255, 1'b1, '{8'd64, 24'd1, 24'd2}},
		'{OP_CLEAR, 8'd170, 8'd85, 8'd15, 8'd240, 1'b0, '{8'd0, 24'd0, 24'd0}},
		'{OP_READ, 8'd0, 8'd0, 8'd0, 8'd127, 1'b1, '{8'd0, 24'd0, 24'd0}},
		'{OP_ACCUMULATE, 8'd128, 8'd64, 8'd32, 8'd0, 1'b0, '{8'd0, 24'd0, 24'd0}},
		'{OP_READ, 8'd0, 8'd0, 8'd0, 8'd80, 1'b1, '{8'd128, 24'd1, 24'd1}},
		'{OP_ACCUMULATE, 8'd170, 8'd85, 8'd240, 8'd15, 1'b0, '{8'd0, 24'd0, 24'd0}},
		'{OP_READ, 8'd0, 8'd0, 8'd0, 8'd85, 1'b0, '{8'd0, 24'd0, 24'd0}}
	};

	pixel_histogram_peak_normalize #(
		.COUNT_BITS(CNT_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.red(red),
		.green(green),
		.blue(blue),
		.bin_index(bin_index),
		.result_valid(result_valid),
		.bin_height(bin_height),
		.raw_count(raw_count),
		.peak_count(peak_count),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic logic [BIN_BITS-1:0] channel_value(input logic [PIX_BITS-1:0] r,
			input logic [PIX_BITS-1:0] g, input logic [PIX_BITS-1:0] b);
		logic [PIX_BITS-1:0] hi;
		logic [PIX_BITS-1:0] lo;
		logic [PIX_BITS:0] sum;
		hi = r;
		lo = r;
		if (g > hi) hi = g;
		if (b > hi) hi = b;
		if (g < lo) lo = g;
		if (b < lo) lo = b;
		sum = {1'b0, hi} + {1'b0, lo};
		case (sel_channel)
			CH_RED: return r;
			CH_GREEN: return g;
			CH_BLUE: return b;
			default: return sum[PIX_BITS:1];
		endcase
	endfunction

	// advance the shadow histogram by one item, returning the bin reading for a read
	task automatic histogram_apply(input logic [1:0] op, input logic [PIX_BITS-1:0] r,
			input logic [PIX_BITS-1:0] g, input logic [PIX_BITS-1:0] b,
			input logic [BIN_BITS-1:0] idx, output bit is_read, output bin_reading_t rd);
		logic [BIN_BITS-1:0] slot;
		logic [CNT_BITS-1:0] cnt;
		logic [63:0] scaled;
		is_read = 1'b0;
		rd = '{default: '0};
		case (op)
			OP_ACCUMULATE: begin
				slot = channel_value(r, g, b);
				cnt = hist_bins[slot];
				if (cnt != CNT_MAX) cnt = cnt + 1'b1;
				hist_bins[slot] = cnt;
				if (cnt > hist_peak) hist_peak = cnt;
			end
			OP_READ: begin
				cnt = hist_bins[idx];
				scaled = 64'd0;
				if (hist_peak != '0) begin
					scaled = (64'(cnt) * 64'(scale_height)) / 64'(hist_peak);
					if (scaled > 64'd255) scaled = 64'd255;
				end
				is_read = 1'b1;
				rd.height = scaled[HEIGHT_BITS-1:0];
				rd.count = cnt[OUT_COUNT_BITS-1:0];
				rd.peak = hist_peak[OUT_COUNT_BITS-1:0];
			end
			OP_CLEAR: begin
				foreach (hist_bins[i]) hist_bins[i] = '0;
				hist_peak = '0;
			end
			default: ;
		endcase
	endtask

	task automatic issue_item(input logic [1:0] op, input logic [PIX_BITS-1:0] r,
			input logic [PIX_BITS-1:0] g, input logic [PIX_BITS-1:0] b,
			input logic [BIN_BITS-1:0] idx, input bit typed, input bin_reading_t typed_rd,
			input int gap);
		bit is_read;
		bin_reading_t rd;
		start <= 1'b1;
		operation <= op;
		red <= r;
		green <= g;
		blue <= b;
		bin_index <= idx;
		@(posedge clk);
		while (busy) @(posedge clk);
		histogram_apply(op, r, g, b, idx, is_read, rd);
		if (is_read) pending_reads.push_back(typed ? typed_rd : rd);
		items_sent++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// accumulates and clears give no result, so let the block finish before touching registers
	task automatic settle_idle();
		start <= 1'b0;
		@(posedge clk);
		while (pending_reads.size() != 0 || busy) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input logic [1:0] ch, input logic [HEIGHT_BITS-1:0] height);
		logic [HEIGHT_BITS-1:0] sel_word;
		sel_word = {6'($urandom), ch};
		cfg_valid <= 1'b1;
		cfg_index <= REG_CHANNEL_SELECT;
		cfg_data <= sel_word;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sel_channel = sel_word[1:0];
		cfg_writes++;
		cfg_index <= REG_BAR_HEIGHT;
		cfg_data <= height;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		scale_height = height;
		cfg_writes++;
		cfg_valid <= 1'b0;
	endtask

	always @(posedge clk) begin
		bin_reading_t want;
		if (arst_n && result_valid) begin
			if (pending_reads.size() == 0) begin
				$error("bin reading with none outstanding: height %0d count %0d peak %0d",
					bin_height, raw_count, peak_count);
				mismatches++;
			end else begin
				want = pending_reads.pop_front();
				reads_checked++;
				if (bin_height !== want.height) begin
					$error("bin_height: expected %0d, got %0d", want.height, bin_height);
					mismatches++;
				end
				if (raw_count !== want.count) begin
					$error("raw_count: expected %0d, got %0d", want.count, raw_count);
					mismatches++;
				end
				if (peak_count !== want.peak) begin
					$error("peak_count: expected %0d, got %0d", want.peak, peak_count);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", STALL_LIMIT);
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		logic [1:0] phase_ch [NUM_PHASES];
		logic [HEIGHT_BITS-1:0] phase_height [NUM_PHASES];
		logic [BIN_BITS-1:0] hot_base;
		logic [1:0] op;
		logic [PIX_BITS-1:0] r;
		logic [PIX_BITS-1:0] g;
		logic [PIX_BITS-1:0] b;
		logic [BIN_BITS-1:0] idx;
		bin_reading_t none;
		bit no_gaps;
		int dice;

		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		operation = OP_ACCUMULATE;
		red = '0;
		green = '0;
		blue = '0;
		bin_index = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_CHANNEL_SELECT;
		cfg_data = '0;
		none = '{default: '0};
		no_gaps = 1'b0;

		foreach (hist_bins[i]) hist_bins[i] = '0;
		hist_peak = '0;
		sel_channel = CHANNEL_SELECT_RESET;
		scale_height = BAR_HEIGHT_RESET;

		phase_ch = '{CH_RED, CH_GREEN, CH_BLUE, CH_LIGHTNESS, CH_BLUE, CH_RED, CH_GREEN,
			CH_LIGHTNESS};
		phase_height = '{8'd255, 8'd1, 8'd0, 8'd255, 8'd200, 8'($urandom_range(1, 255)),
			8'($urandom_range(1, 255)), 8'd128};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i])
			issue_item(dir_tab[i].op, dir_tab[i].r, dir_tab[i].g, dir_tab[i].b,
				dir_tab[i].idx, dir_tab[i].typed, dir_tab[i].want, $urandom_range(0, 3));

		for (int p = 0; p < NUM_PHASES; p++) begin
			settle_idle();
			configure(phase_ch[p], phase_height[p]);
			hot_base = 8'($urandom_range(0, 248));
			if (p == 2 || p == 5) hot_base = (p == 2) ? 8'd248 : 8'd0;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 29) == 0) no_gaps = !no_gaps;
				dice = $urandom_range(0, 99);
				if (dice < 65) op = OP_ACCUMULATE;
				else if (dice < 90) op = OP_READ;
				else if (dice < 93) op = OP_CLEAR;
				else op = OP_UNUSED;
				// most pixels land in a narrow band so counts build up
				if ($urandom_range(0, 9) < 6) begin
					r = hot_base + 8'($urandom_range(0, 7));
					g = hot_base + 8'($urandom_range(0, 7));
					b = hot_base + 8'($urandom_range(0, 7));
				end else begin
					r = 8'($urandom);
					g = 8'($urandom);
					b = 8'($urandom);
				end
				if ($urandom_range(0, 9) < 6) idx = hot_base + 8'($urandom_range(0, 7));
				else idx = 8'($urandom);
				issue_item(op, r, g, b, idx, 1'b0, none,
					no_gaps ? 0 : $urandom_range(0, 10));
			end
		end

		settle_idle();
		$display("%0d items sent (%0d bin reads checked), %0d register writes over %0d settings",
			items_sent, reads_checked, cfg_writes, NUM_PHASES);
		$display("covered all four channel selects, bar heights 0 to 255, clears and unused codes");
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

/* filelist.f */
src/hpn_pkg.sv
src/hpn_ctrl.sv
src/hpn_div.sv
src/hpn_datapath.sv
src/pixel_histogram_peak_normalize.sv
tb/sv/tb_top.sv
